// ----- rtl/swod_pkg.sv -----
// Shared constants, codes and types for the sliding-window overload detector.
package swod_pkg;

  localparam int unsigned RESP_TIME_W = 32;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOW_THRESHOLD = 3'd0,
    CFG_RESP_LEN       = 3'd1,
    CFG_CONN_LEN       = 3'd2,
    CFG_SLOW_LIMIT     = 3'd3,
    CFG_DISC_LIMIT     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    FUNC_RESP = 1'b0,
    FUNC_CONN = 1'b1
  } func_e;

  typedef struct packed {
    logic             overload;
    logic [CNT_W-1:0] slow_count;
    logic [CNT_W-1:0] disconnect_count;
  } result_t;

endpackage

// ----- rtl/swod_ifs.sv -----
// Handshake interfaces for the sample, result and configuration channels.
interface swod_sample_if;
  import swod_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [RESP_TIME_W-1:0] rsp_ms;
  logic                   conn_disconnected;
  modport source (output valid, func, rsp_ms, conn_disconnected, input ready);
  modport sink   (input valid, func, rsp_ms, conn_disconnected, output ready);
endinterface

interface swod_result_if;
  import swod_pkg::*;
  logic             valid;
  logic             ready;
  logic             overload;
  logic [CNT_W-1:0] slow_count;
  logic [CNT_W-1:0] disconnect_count;
  modport source (output valid, overload, slow_count, disconnect_count, input ready);
  modport sink   (input valid, overload, slow_count, disconnect_count, output ready);
endinterface

interface swod_cfg_if;
  import swod_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/swod_ram.sv -----
// Generic single-write, single-read RAM with registered, read-first output.
module swod_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sliding_window_overload_detector.sv -----
// Top level: two flag rings in RAM, window counters and a result queue.
// An accepted request is registered into stage 1, which queues its result.
// Throughput: one request per cycle while the queue has room; the ring RAM read
// of the oldest flag is registered, so the count update lands in the next stage.
// A four-entry result queue absorbs output stalls; ready drops when it could fill.
// Reset clears pointers, fills, counts and registers; the rings need no clearing.
module sliding_window_overload_detector #(
  parameter int unsigned WINDOW_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  swod_cfg_if.sink      cfg_i,
  swod_sample_if.sink   sample_i,
  swod_result_if.source result_o
);
  import swod_pkg::*;

  localparam int unsigned PtrW      = $clog2(WINDOW_DEPTH);
  localparam int unsigned FillW     = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
  localparam logic [FillW-1:0] DepthFill = FillW'(WINDOW_DEPTH);
  localparam logic [PtrW-1:0]  LastPtr   = PtrW'(WINDOW_DEPTH - 1);

  // configuration registers
  logic [RESP_TIME_W-1:0] slow_thr_q;
  logic [CNT_W-1:0]       resp_len_q, conn_len_q, slow_limit_q, disc_limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_thr_q   <= RESP_TIME_W'(10);
      resp_len_q   <= CNT_W'(200);
      conn_len_q   <= CNT_W'(200);
      slow_limit_q <= CNT_W'(10);
      disc_limit_q <= CNT_W'(10);
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_SLOW_THRESHOLD: slow_thr_q   <= cfg_i.data;
        CFG_RESP_LEN:       resp_len_q   <= cfg_i.data[CNT_W-1:0];
        CFG_CONN_LEN:       conn_len_q   <= cfg_i.data[CNT_W-1:0];
        CFG_SLOW_LIMIT:     slow_limit_q <= cfg_i.data[CNT_W-1:0];
        CFG_DISC_LIMIT:     disc_limit_q <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [FillW-1:0] clamp_len(input logic [CNT_W-1:0] len);
    if (len == '0) begin
      return FillW'(1);
    end else if (32'(len) > 32'(WINDOW_DEPTH)) begin
      return DepthFill;
    end
    return FillW'(len);
  endfunction

  // oldest slot = (wr - fill) mod depth
  function automatic logic [PtrW-1:0] oldest_addr(input logic [PtrW-1:0]  wr,
                                                  input logic [FillW-1:0] fill);
    logic [FillW:0] w;
    logic [FillW:0] f;
    w = (FillW + 1)'(wr);
    f = (FillW + 1)'(fill);
    if (w >= f) begin
      return PtrW'(w - f);
    end
    return PtrW'(w + (FillW + 1)'(DepthFill) - f);
  endfunction

  // stage 0: accept, write new flag, read oldest flag
  logic accept;
  logic flag_new;
  logic ring_evict [2];
  logic ring_rdata [2];

  logic s1_valid_q;
  logic s1_ring_q, s1_evict_q, s1_flag_q;

  logic [FifoCntW-1:0] fifo_cnt_q;

  assign sample_i.ready = (fifo_cnt_q + FifoCntW'(s1_valid_q)) < FifoCntW'(FifoDepth);
  assign accept   = sample_i.valid && sample_i.ready;
  assign flag_new = (sample_i.func == FUNC_CONN) ? sample_i.conn_disconnected
                                                 : (sample_i.rsp_ms > slow_thr_q);

  for (genvar r = 0; r < 2; r++) begin : g_ring
    logic [PtrW-1:0]  wr_q, wr_d, rd_addr;
    logic [FillW-1:0] fill_q, fill_d, fill_ev, len;
    logic             hit, evict;

    assign hit = accept && (sample_i.func == 1'(r));

    always_comb begin
      len     = clamp_len((r == 0) ? resp_len_q : conn_len_q);
      evict   = (fill_q >= len);
      fill_ev = evict ? fill_q - FillW'(1) : fill_q;
      fill_d  = (fill_ev < DepthFill) ? fill_ev + FillW'(1) : fill_ev;
      wr_d    = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      rd_addr = oldest_addr(wr_q, fill_q);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        wr_q   <= '0;
        fill_q <= '0;
      end else if (hit) begin
        wr_q   <= wr_d;
        fill_q <= fill_d;
      end
    end

    assign ring_evict[r] = evict;

    swod_ram #(
      .WIDTH(1),
      .DEPTH(WINDOW_DEPTH)
    ) u_ring_ram (
      .clk_i  (clk_i),
      .we_i   (hit),
      .waddr_i(wr_q),
      .wdata_i(flag_new),
      .raddr_i(rd_addr),
      .rdata_o(ring_rdata[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ring_q  <= sample_i.func;
      s1_evict_q <= ring_evict[sample_i.func];
      s1_flag_q  <= flag_new;
    end
  end

  // stage 1: count update from the evicted flag, result into queue
  logic [FillW-1:0] total_q [2];
  logic [FillW-1:0] total_new [2];
  logic [FillW-1:0] tot_cur, tot_dec, tot_inc;
  result_t          res;

  always_comb begin
    tot_cur = total_q[s1_ring_q];
    tot_dec = (s1_evict_q && ring_rdata[s1_ring_q] && (tot_cur != '0))
              ? tot_cur - FillW'(1) : tot_cur;
    tot_inc = (s1_flag_q && (tot_dec < DepthFill)) ? tot_dec + FillW'(1) : tot_dec;
    total_new[0] = (s1_ring_q == FUNC_RESP) ? tot_inc : total_q[0];
    total_new[1] = (s1_ring_q == FUNC_CONN) ? tot_inc : total_q[1];
    res.overload = (32'(total_new[0]) >= 32'(slow_limit_q))
                || (32'(total_new[1]) >= 32'(disc_limit_q));
    res.slow_count       = CNT_W'(total_new[0]);
    res.disconnect_count = CNT_W'(total_new[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q[0] <= '0;
      total_q[1] <= '0;
    end else if (s1_valid_q) begin
      total_q[0] <= total_new[0];
      total_q[1] <= total_new[1];
    end
  end

  // result queue
  result_t             fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] fifo_wp_q, fifo_rp_q;
  logic                push, pop;
  result_t             head;

  assign push = s1_valid_q;
  assign pop  = result_o.valid && result_o.ready;
  assign head = fifo_q[fifo_rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wp_q  <= '0;
      fifo_rp_q  <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        fifo_wp_q <= fifo_wp_q + FifoPtrW'(1);
      end
      if (pop) begin
        fifo_rp_q <= fifo_rp_q + FifoPtrW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FifoCntW'(push) - FifoCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[fifo_wp_q] <= res;
    end
  end

  assign result_o.valid            = (fifo_cnt_q != '0);
  assign result_o.overload         = head.overload;
  assign result_o.slow_count       = head.slow_count;
  assign result_o.disconnect_count = head.disconnect_count;

  // assertions
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (fifo_cnt_q < FifoCntW'(FifoDepth)))
    else $error("result queue overflow");

  a_stage_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted request did not reach count stage");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q[0] <= DepthFill) && (total_q[1] <= DepthFill))
    else $error("window count above depth");

endmodule
